// ===== hdl/hbm_pkg.sv =====
// shared types and constants for the binaural hrtf mixer
// no dependencies

package hbm_pkg;

    localparam int HBM_IR_LEN   = 128;
    localparam int HBM_HIST_LEN = 64;

    localparam logic OP_PROCESS = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    localparam logic [2:0] CFG_IR_SIZE       = 3'd0;
    localparam logic [2:0] CFG_BLEND_MODE    = 3'd1;
    localparam logic [2:0] CFG_NEW_DELAYS    = 3'd2;
    localparam logic [2:0] CFG_OLD_DELAYS    = 3'd3;
    localparam logic [2:0] CFG_NEW_GAIN      = 3'd4;
    localparam logic [2:0] CFG_NEW_GAIN_STEP = 3'd5;
    localparam logic [2:0] CFG_OLD_GAIN      = 3'd6;
    localparam logic [2:0] CFG_OLD_GAIN_STEP = 3'd7;

    typedef struct packed {
        logic clear;
        logic proc;
        logic load;
        logic head;
        logic tap_l;
        logic tap_r;
        logic gain;
        logic mac;
        logic out_rd;
        logic out_load;
        logic set_old;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic mac_last;
        logic blend;
    } t_sts;

endpackage

// ===== hdl/hrtf_binaural_mixer_blend.sv =====
// a sample runs one mac pass over n taps (n = clamped ir_size), two passes when
// crossfading, old set first; the next sample is accepted only once the result is
// registered, and both ears take one mac per cycle per tap during a pass
// coefficient loads are written while idle; reset runs a clearing pass over the
// history and accumulator rams

module hrtf_binaural_mixer_blend #(
    parameter int IR_LEN   = hbm_pkg::HBM_IR_LEN,
    parameter int HIST_LEN = hbm_pkg::HBM_HIST_LEN
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_opcode,
    input  logic signed [23:0] i_sample_in,
    input  logic signed [23:0] i_mix_in_left,
    input  logic signed [23:0] i_mix_in_right,
    input  logic               i_first_of_buffer,
    input  logic               i_coeff_bank,
    input  logic [6:0]         i_coeff_index,
    input  logic signed [23:0] i_coeff_left,
    input  logic signed [23:0] i_coeff_right,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [23:0] o_left_out,
    output logic signed [23:0] o_right_out,
    output logic [23:0]        o_running_gain,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    import hbm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    hbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    hbm_dp #(.IR_LEN(IR_LEN), .HIST_LEN(HIST_LEN)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_sample_in       (i_sample_in),
        .i_mix_in_left     (i_mix_in_left),
        .i_mix_in_right    (i_mix_in_right),
        .i_first_of_buffer (i_first_of_buffer),
        .i_coeff_bank      (i_coeff_bank),
        .i_coeff_index     (i_coeff_index),
        .i_coeff_left      (i_coeff_left),
        .i_coeff_right     (i_coeff_right),
        .o_left_out        (o_left_out),
        .o_right_out       (o_right_out),
        .o_running_gain    (o_running_gain)
    );

endmodule

// ===== hdl/hbm_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies

module hbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/hbm_ctrl.sv =====
// sequencer for the binaural mixer: clear pass, per-set tap and mac passes, output
// depends on hbm_pkg

module hbm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_opcode,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  hbm_pkg::t_sts i_sts,
    output hbm_pkg::t_cmd o_cmd
);

    import hbm_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HEAD, S_TAPL, S_TAPR, S_GAIN, S_MAC,
        S_DRAIN1, S_DRAIN2, S_OUTRD, S_FIN
    } t_state;

    t_state r_state;
    logic   r_set_old;
    logic   r_out_valid;
    logic   w_idle;

    assign w_idle = (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.clear    = (r_state == S_CLEAR);
        o_cmd.proc     = w_idle && i_in_valid && (i_opcode == OP_PROCESS);
        o_cmd.load     = w_idle && i_in_valid && (i_opcode == OP_LOAD);
        o_cmd.head     = (r_state == S_HEAD);
        o_cmd.tap_l    = (r_state == S_TAPL);
        o_cmd.tap_r    = (r_state == S_TAPR);
        o_cmd.gain     = (r_state == S_GAIN);
        o_cmd.mac      = (r_state == S_MAC);
        o_cmd.out_rd   = (r_state == S_OUTRD);
        o_cmd.out_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
        o_cmd.set_old  = r_set_old;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_set_old   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (i_sts.clear_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_cmd.proc) begin
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    // old set goes first when crossfading
                    r_set_old <= i_sts.blend;
                    r_state   <= S_TAPL;
                end
                S_TAPL:   r_state <= S_TAPR;
                S_TAPR:   r_state <= S_GAIN;
                S_GAIN:   r_state <= S_MAC;
                S_MAC: begin
                    if (i_sts.mac_last) begin
                        if (r_set_old) begin
                            r_set_old <= 1'b0;
                            r_state   <= S_TAPL;
                        end else begin
                            r_state <= S_DRAIN1;
                        end
                    end
                end
                S_DRAIN1: r_state <= S_DRAIN2;
                S_DRAIN2: r_state <= S_OUTRD;
                S_OUTRD:  r_state <= S_FIN;
                S_FIN: begin
                    if (o_cmd.out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = !w_idle;
    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/hbm_dp.sv =====
// datapath of the binaural mixer: config registers, history, coefficient and
// accumulator rams, tap scaling and mac pipeline; depends on hbm_pkg, hbm_ram

module hbm_dp #(
    parameter int IR_LEN   = hbm_pkg::HBM_IR_LEN,
    parameter int HIST_LEN = hbm_pkg::HBM_HIST_LEN
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hbm_pkg::t_cmd      i_cmd,
    output hbm_pkg::t_sts      o_sts,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic signed [23:0] i_sample_in,
    input  logic signed [23:0] i_mix_in_left,
    input  logic signed [23:0] i_mix_in_right,
    input  logic               i_first_of_buffer,
    input  logic               i_coeff_bank,
    input  logic [6:0]         i_coeff_index,
    input  logic signed [23:0] i_coeff_left,
    input  logic signed [23:0] i_coeff_right,
    output logic signed [23:0] o_left_out,
    output logic signed [23:0] o_right_out,
    output logic [23:0]        o_running_gain
);

    import hbm_pkg::*;

    localparam int IR_AW     = $clog2(IR_LEN);
    localparam int HIST_AW   = $clog2(HIST_LEN);
    localparam int CLR_DEPTH = (IR_LEN > HIST_LEN) ? IR_LEN : HIST_LEN;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);

    // configuration
    logic [7:0]         r_ir_size;
    logic               r_blend;
    logic [11:0]        r_new_delays;
    logic [11:0]        r_old_delays;
    logic [23:0]        r_new_gain;
    logic signed [23:0] r_new_step;
    logic [23:0]        r_old_gain;
    logic signed [23:0] r_old_step;

    logic [CLR_AW-1:0]  r_clr_cnt;
    logic [CLR_AW-1:0]  r_pos;
    logic [IR_AW-1:0]   r_c;
    logic [23:0]        r_ramp_new;
    logic [23:0]        r_ramp_old;

    logic signed [23:0] r_sample;
    logic signed [23:0] r_mix_l;
    logic signed [23:0] r_mix_r;
    logic signed [23:0] r_hist_l;
    logic signed [26:0] r_tap_l;
    logic signed [26:0] r_tap_r;

    logic               r_v1;
    logic [IR_AW-1:0]   r_k1;
    logic               r_v2;
    logic [IR_AW-1:0]   r_k2;
    logic signed [50:0] r_prod_l;
    logic signed [50:0] r_prod_r;
    logic signed [31:0] r_acc_l2;
    logic signed [31:0] r_acc_r2;

    logic signed [23:0] r_out_left;
    logic signed [23:0] r_out_right;
    logic [23:0]        r_out_gain;

    // ram ports
    logic [HIST_AW-1:0] w_hwaddr, w_hraddr;
    logic [23:0]        w_hwdata, w_hrdata;
    logic               w_hwe, w_hre;
    logic [IR_AW:0]     w_cwaddr, w_craddr;
    logic [47:0]        w_crdata;
    logic [IR_AW-1:0]   w_awaddr, w_araddr;
    logic [63:0]        w_awdata, w_ardata;
    logic               w_awe, w_are;

    logic [IR_AW-1:0]   w_ipos;
    logic [HIST_AW-1:0] w_hpos;
    logic [IR_AW:0]     w_n;
    logic [IR_AW:0]     w_n_m1_full;
    logic [IR_AW-1:0]   w_nm1;
    logic [IR_AW-1:0]   w_head;
    logic [IR_AW-1:0]   w_k;
    logic [11:0]        w_dly;
    logic [HIST_AW-1:0] w_dl, w_dr;

    logic [23:0]        w_gain;
    logic signed [23:0] w_step;
    logic signed [48:0] w_hprod_l, w_hprod_r, w_hrnd_l, w_hrnd_r;
    logic signed [25:0] w_ramp_sum;
    logic [23:0]        w_ramp_next;

    logic signed [23:0] w_cl, w_cr;
    logic signed [50:0] w_mul_l, w_mul_r, w_crnd_l, w_crnd_r;
    logic signed [32:0] w_sum_l, w_sum_r;
    logic signed [31:0] w_new_l, w_new_r;
    logic signed [32:0] w_osum_l, w_osum_r;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            sat32 = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [32:0] v);
        if (v[32:23] == '0 || v[32:23] == '1) begin
            sat24 = v[23:0];
        end else begin
            sat24 = v[32] ? 24'sh80_0000 : 24'sh7F_FFFF;
        end
    endfunction

    assign w_ipos = r_pos[IR_AW-1:0];
    assign w_hpos = r_pos[HIST_AW-1:0];

    // filter length clamped to 4..IR_LEN
    always_comb begin
        if (r_ir_size < 8'd4) begin
            w_n = (IR_AW+1)'(4);
        end else if (32'(r_ir_size) > 32'(IR_LEN)) begin
            w_n = (IR_AW+1)'(IR_LEN);
        end else begin
            w_n = (IR_AW+1)'(r_ir_size);
        end
    end
    assign w_n_m1_full = w_n - 1'b1;
    assign w_nm1       = w_n_m1_full[IR_AW-1:0];
    assign w_head      = w_ipos + w_nm1;
    assign w_k         = w_ipos + r_c;

    assign w_dly = i_cmd.set_old ? r_old_delays : r_new_delays;
    assign w_dl  = HIST_AW'(w_dly[5:0]);
    assign w_dr  = HIST_AW'(w_dly[11:6]);

    // history ring
    assign w_hwe    = i_cmd.clear || i_cmd.head;
    assign w_hwaddr = i_cmd.clear ? r_clr_cnt[HIST_AW-1:0] : w_hpos;
    assign w_hwdata = i_cmd.clear ? 24'd0 : r_sample;
    assign w_hre    = i_cmd.tap_l || i_cmd.tap_r;
    assign w_hraddr = i_cmd.tap_l ? (w_hpos - w_dl) : (w_hpos - w_dr);

    hbm_ram #(.WIDTH(24), .DEPTH(HIST_LEN)) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_hwe),
        .i_waddr (w_hwaddr),
        .i_wdata (w_hwdata),
        .i_re    (w_hre),
        .i_raddr (w_hraddr),
        .o_rdata (w_hrdata)
    );

    // coefficient tables, bank bit on top of the tap index
    assign w_cwaddr = {i_coeff_bank, IR_AW'(i_coeff_index)};
    assign w_craddr = {i_cmd.set_old, r_c};

    hbm_ram #(.WIDTH(48), .DEPTH(2*IR_LEN)) u_coeff (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (w_cwaddr),
        .i_wdata ({i_coeff_left, i_coeff_right}),
        .i_re    (i_cmd.mac),
        .i_raddr (w_craddr),
        .o_rdata (w_crdata)
    );

    // accumulator ring, left in the upper half
    assign w_awe    = i_cmd.clear || i_cmd.head || r_v2;
    assign w_awaddr = i_cmd.clear ? r_clr_cnt[IR_AW-1:0] : (i_cmd.head ? w_head : r_k2);
    assign w_awdata = (i_cmd.clear || i_cmd.head) ? 64'd0 : {w_new_l, w_new_r};
    assign w_are    = i_cmd.mac || i_cmd.out_rd;
    assign w_araddr = i_cmd.mac ? w_k : w_ipos;

    hbm_ram #(.WIDTH(64), .DEPTH(IR_LEN)) u_accum (
        .i_clk   (i_clk),
        .i_we    (w_awe),
        .i_waddr (w_awaddr),
        .i_wdata (w_awdata),
        .i_re    (w_are),
        .i_raddr (w_araddr),
        .o_rdata (w_ardata)
    );

    // tap scaling with round half up, q2.22 gain
    assign w_gain    = i_cmd.set_old ? r_ramp_old : r_ramp_new;
    assign w_step    = i_cmd.set_old ? r_old_step : r_new_step;
    assign w_hprod_l = r_hist_l * $signed({1'b0, w_gain});
    assign w_hprod_r = $signed(w_hrdata) * $signed({1'b0, w_gain});
    assign w_hrnd_l  = w_hprod_l + 49'sd2097152;
    assign w_hrnd_r  = w_hprod_r + 49'sd2097152;

    assign w_ramp_sum = $signed({2'b00, w_gain}) + {{2{w_step[23]}}, w_step};
    always_comb begin
        if (w_ramp_sum[25]) begin
            w_ramp_next = 24'd0;
        end else if (w_ramp_sum[24]) begin
            w_ramp_next = 24'hFF_FFFF;
        end else begin
            w_ramp_next = w_ramp_sum[23:0];
        end
    end

    // mac pipeline: read, multiply, round and accumulate
    assign w_cl     = w_crdata[47:24];
    assign w_cr     = w_crdata[23:0];
    assign w_mul_l  = r_tap_l * w_cl;
    assign w_mul_r  = r_tap_r * w_cr;
    assign w_crnd_l = r_prod_l + 51'sd4194304;
    assign w_crnd_r = r_prod_r + 51'sd4194304;
    assign w_sum_l  = {r_acc_l2[31], r_acc_l2} + {{5{w_crnd_l[50]}}, w_crnd_l[50:23]};
    assign w_sum_r  = {r_acc_r2[31], r_acc_r2} + {{5{w_crnd_r[50]}}, w_crnd_r[50:23]};
    assign w_new_l  = sat32(w_sum_l);
    assign w_new_r  = sat32(w_sum_r);

    assign w_osum_l = {{9{r_mix_l[23]}}, r_mix_l} + {w_ardata[63], w_ardata[63:32]};
    assign w_osum_r = {{9{r_mix_r[23]}}, r_mix_r} + {w_ardata[31], w_ardata[31:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ir_size    <= 8'd32;
            r_blend      <= 1'b0;
            r_new_delays <= 12'd0;
            r_old_delays <= 12'd0;
            r_new_gain   <= 24'd4194304;
            r_new_step   <= 24'sd0;
            r_old_gain   <= 24'd0;
            r_old_step   <= 24'sd0;
            r_clr_cnt    <= '0;
            r_pos        <= '0;
            r_c          <= '0;
            r_ramp_new   <= 24'd0;
            r_ramp_old   <= 24'd0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IR_SIZE:       r_ir_size    <= i_cfg_data[7:0];
                    CFG_BLEND_MODE:    r_blend      <= i_cfg_data[0];
                    CFG_NEW_DELAYS:    r_new_delays <= i_cfg_data[11:0];
                    CFG_OLD_DELAYS:    r_old_delays <= i_cfg_data[11:0];
                    CFG_NEW_GAIN:      r_new_gain   <= i_cfg_data;
                    CFG_NEW_GAIN_STEP: r_new_step   <= $signed(i_cfg_data);
                    CFG_OLD_GAIN:      r_old_gain   <= i_cfg_data;
                    CFG_OLD_GAIN_STEP: r_old_step   <= $signed(i_cfg_data);
                    default:           r_ir_size    <= r_ir_size;
                endcase
            end
            if (i_cmd.clear) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.proc && i_first_of_buffer) begin
                r_ramp_new <= r_blend ? 24'd0 : r_new_gain;
                r_ramp_old <= r_old_gain;
            end
            if (i_cmd.gain) begin
                r_c <= '0;
                if (i_cmd.set_old) begin
                    r_ramp_old <= w_ramp_next;
                end else begin
                    r_ramp_new <= w_ramp_next;
                end
            end else if (i_cmd.mac) begin
                r_c <= r_c + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_pos <= r_pos + 1'b1;
            end
            r_v1 <= i_cmd.mac;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.proc) begin
            r_sample <= i_sample_in;
            r_mix_l  <= i_mix_in_left;
            r_mix_r  <= i_mix_in_right;
        end
        if (i_cmd.tap_r) begin
            r_hist_l <= $signed(w_hrdata);
        end
        if (i_cmd.gain) begin
            r_tap_l <= w_hrnd_l[48:22];
            r_tap_r <= w_hrnd_r[48:22];
        end
        r_k1 <= w_k;
        if (r_v1) begin
            r_k2     <= r_k1;
            r_prod_l <= w_mul_l;
            r_prod_r <= w_mul_r;
            r_acc_l2 <= w_ardata[63:32];
            r_acc_r2 <= w_ardata[31:0];
        end
        if (i_cmd.out_load) begin
            r_out_left  <= sat24(w_osum_l);
            r_out_right <= sat24(w_osum_r);
            r_out_gain  <= r_ramp_new;
        end
    end

    assign o_sts.clear_last = (r_clr_cnt == CLR_AW'(CLR_DEPTH - 1));
    assign o_sts.mac_last   = (r_c == w_nm1);
    assign o_sts.blend      = r_blend;

    assign o_left_out     = r_out_left;
    assign o_right_out    = r_out_right;
    assign o_running_gain = r_out_gain;

endmodule
